// File: hw/rtl/ipv4_source_rewrite_checksum_unit_defines.svh
// Assertion macros for the IPv4 source rewrite checksum unit checker.
`ifndef IPV4_SOURCE_REWRITE_CHECKSUM_UNIT_DEFINES_SVH
`define IPV4_SOURCE_REWRITE_CHECKSUM_UNIT_DEFINES_SVH

// Checked on every clock while out of reset.
`define ISRC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("isrc check failed");

// Checked on every clock, reset included.
`define ISRC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("isrc reset check failed");

`endif

// File: hw/rtl/isrc_pkg.sv
// Shared types, constants and helpers for the IPv4 source rewrite checksum unit.
package isrc_pkg;

    localparam int MAX_HEADER_WORDS = 30;
    localparam int HDR_AW           = $clog2(MAX_HEADER_WORDS);
    localparam int CNT_W            = $clog2(MAX_HEADER_WORDS + 1);
    localparam int SUM_W            = 21;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);

    localparam logic [31:0]       SRC_ADDR_RESET = 32'hC0A8_0164;
    localparam logic [3:0]        MIN_IHL        = 4'd5;
    localparam logic [HDR_AW-1:0] CKSUM_IDX      = HDR_AW'(5);
    localparam logic [HDR_AW-1:0] SRC_HI_IDX     = HDR_AW'(6);
    localparam logic [HDR_AW-1:0] SRC_LO_IDX     = HDR_AW'(7);

    typedef enum logic [1:0] {
        FS_HEADER,
        FS_PAYLOAD,
        FS_REPLAY
    } front_state_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_READ,
        BS_EMIT
    } back_state_t;

    typedef enum logic {
        CMD_PASS,
        CMD_REPLAY
    } cmd_kind_t;

    // word: pass-through data, or the checksum for a header replay
    typedef struct packed {
        cmd_kind_t        kind;
        logic [15:0]      word;
        logic             eop;
        logic             odd;
        logic             bad;
        logic [CNT_W-1:0] count;
    } cmd_t;

    // Header word as it enters the checksum: checksum zeroed, source replaced.
    function automatic logic [15:0] rewrite_word(logic [HDR_AW-1:0] idx,
                                                 logic [15:0] w,
                                                 logic [31:0] addr);
        logic [15:0] r;
        r = w;
        if (idx == CKSUM_IDX) begin
            r = 16'h0000;
        end else if (idx == SRC_HI_IDX) begin
            r = addr[31:16];
        end else if (idx == SRC_LO_IDX) begin
            r = addr[15:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/isrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module isrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/isrc_front.sv
// Front end: accepts words, buffers the header, sums it and issues commands.
module isrc_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,
    input  logic                      s_tlast,
    input  logic                      s_tuser,
    input  logic [31:0]               src_addr,
    input  logic                      q_full,
    output logic                      q_push,
    output isrc_pkg::cmd_t            q_cmd,
    output logic                      ram_we,
    output logic [isrc_pkg::HDR_AW-1:0] ram_waddr,
    output logic [15:0]               ram_wdata,
    input  logic                      replay_done
);
    import isrc_pkg::*;

    front_state_t     state_reg, state_next;
    logic [HDR_AW-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] hcount_reg, hcount_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             bad_reg, bad_next;
    logic             resume_reg, resume_next;

    logic             accept;
    logic             odd;
    logic [3:0]       ihl;
    logic             ihl_bad;
    logic [CNT_W-1:0] hc;
    logic [CNT_W-1:0] pos_p1;
    logic [SUM_W-1:0] sum_base;
    logic [SUM_W-1:0] sum_new;
    logic [16:0]      fold1;
    logic [15:0]      fold2;
    logic [15:0]      cksum;
    logic             hdr_short;
    logic             hdr_done;

    assign s_tready = (state_reg != FS_REPLAY) && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign odd      = s_tlast && s_tuser;
    assign ihl      = s_tdata[11:8];
    assign ihl_bad  = (ihl < MIN_IHL) || ({1'b0, ihl, 1'b0} > 6'(MAX_HEADER_WORDS));
    assign hc       = (pos_reg == '0) ? CNT_W'({ihl, 1'b0}) : hcount_reg;
    assign pos_p1   = CNT_W'(pos_reg) + CNT_W'(1);
    assign sum_base = (pos_reg == '0) ? '0 : sum_reg;
    assign sum_new  = sum_base + SUM_W'(rewrite_word(pos_reg, s_tdata, src_addr));
    assign fold1    = 17'(sum_new[SUM_W-1:16]) + 17'(sum_new[15:0]);
    assign fold2    = fold1[15:0] + 16'(fold1[16]);
    assign cksum    = ~fold2;
    assign hdr_short = s_tlast && ((pos_p1 < hc) || odd);
    assign hdr_done  = (pos_p1 == hc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= FS_HEADER;
            pos_reg    <= '0;
            hcount_reg <= '0;
            sum_reg    <= '0;
            bad_reg    <= 1'b0;
            resume_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            hcount_reg <= hcount_next;
            sum_reg    <= sum_next;
            bad_reg    <= bad_next;
            resume_reg <= resume_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        hcount_next = hcount_reg;
        sum_next    = sum_reg;
        bad_next    = bad_reg;
        resume_next = resume_reg;
        q_push      = 1'b0;
        q_cmd       = '0;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = s_tdata;

        case (state_reg)
            FS_HEADER: begin
                if (accept) begin
                    if ((pos_reg == '0) && ihl_bad) begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_PASS;
                        q_cmd.word = s_tdata;
                        q_cmd.eop  = s_tlast;
                        q_cmd.odd  = odd;
                        q_cmd.bad  = 1'b1;
                        if (!s_tlast) begin
                            state_next = FS_PAYLOAD;
                            bad_next   = 1'b1;
                        end
                    end else begin
                        ram_we      = 1'b1;
                        sum_next    = sum_new;
                        hcount_next = hc;
                        if (hdr_short) begin
                            q_push      = 1'b1;
                            q_cmd.kind  = CMD_REPLAY;
                            q_cmd.eop   = 1'b1;
                            q_cmd.odd   = odd;
                            q_cmd.bad   = 1'b1;
                            q_cmd.count = pos_p1;
                            state_next  = FS_REPLAY;
                            resume_next = 1'b0;
                            pos_next    = '0;
                        end else if (hdr_done) begin
                            q_push      = 1'b1;
                            q_cmd.kind  = CMD_REPLAY;
                            q_cmd.word  = cksum;
                            q_cmd.eop   = s_tlast;
                            q_cmd.odd   = 1'b0;
                            q_cmd.bad   = 1'b0;
                            q_cmd.count = hc;
                            state_next  = FS_REPLAY;
                            resume_next = !s_tlast;
                            bad_next    = 1'b0;
                            pos_next    = '0;
                        end else begin
                            pos_next = pos_reg + HDR_AW'(1);
                        end
                    end
                end
            end
            FS_PAYLOAD: begin
                if (accept) begin
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_PASS;
                    q_cmd.word = s_tdata;
                    q_cmd.eop  = s_tlast;
                    q_cmd.odd  = odd;
                    q_cmd.bad  = bad_reg;
                    if (s_tlast) begin
                        state_next = FS_HEADER;
                    end
                end
            end
            FS_REPLAY: begin
                if (replay_done) begin
                    state_next = resume_reg ? FS_PAYLOAD : FS_HEADER;
                end
            end
            default: begin
                state_next = FS_HEADER;
            end
        endcase
    end

endmodule

// File: hw/rtl/isrc_queue.sv
// Small command queue between the front and back ends.
module isrc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  isrc_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output isrc_pkg::cmd_t head_cmd,
    output logic           empty
);
    import isrc_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hw/rtl/isrc_back.sv
// Back end: passes words through and replays buffered headers, with the checksum unless flagged bad.
module isrc_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    input  isrc_pkg::cmd_t              q_head,
    output logic                        q_pop,
    output logic                        ram_re,
    output logic [isrc_pkg::HDR_AW-1:0] ram_raddr,
    input  logic [15:0]                 ram_rdata,
    input  logic [31:0]                 src_addr,
    output logic                        replay_done,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,
    output logic                        m_tlast,
    output logic [1:0]                  m_tuser
);
    import isrc_pkg::*;

    back_state_t       state_reg, state_next;
    logic [HDR_AW-1:0] idx_reg, idx_next;
    cmd_t              cmd_reg, cmd_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;

    logic              out_free;
    logic              fin;
    logic              rp_last;
    logic [15:0]       rp_word;

    assign out_free = !m_tvalid_reg || m_tready;
    assign fin      = ((CNT_W'(idx_reg) + CNT_W'(1)) == cmd_reg.count);
    assign rp_last  = fin && cmd_reg.eop;
    assign rp_word  = cmd_reg.bad ? ram_rdata :
                      (idx_reg == CKSUM_IDX) ? cmd_reg.word :
                      rewrite_word(idx_reg, ram_rdata, src_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BS_IDLE;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd_next      = cmd_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        q_pop         = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = idx_reg;
        replay_done   = 1'b0;

        case (state_reg)
            BS_IDLE: begin
                if (!q_empty) begin
                    if (q_head.kind == CMD_PASS) begin
                        if (out_free) begin
                            q_pop         = 1'b1;
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = q_head.word;
                            m_tlast_next  = q_head.eop;
                            m_tuser_next  = {q_head.bad, q_head.eop && q_head.odd};
                        end
                    end else begin
                        q_pop      = 1'b1;
                        cmd_next   = q_head;
                        idx_next   = '0;
                        state_next = BS_READ;
                    end
                end
            end
            BS_READ: begin
                ram_re     = 1'b1;
                state_next = BS_EMIT;
            end
            BS_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rp_word;
                    m_tlast_next  = rp_last;
                    m_tuser_next  = {cmd_reg.bad, rp_last && cmd_reg.odd};
                    if (fin) begin
                        replay_done = 1'b1;
                        state_next  = BS_IDLE;
                    end else begin
                        idx_next   = idx_reg + HDR_AW'(1);
                        state_next = BS_READ;
                    end
                end
            end
            default: begin
                state_next = BS_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: hw/rtl/ipv4_source_rewrite_checksum_unit.sv
// Top level: IPv4 source address rewrite with header checksum regeneration.
// Payload words pass through the command queue and the output register, one
// word per cycle while the output is not stalled. Header words are taken one per
// cycle while the queue has room; the header is then replayed word by word from
// the buffer RAM (read then emit), input held meanwhile.
// Reset clears all control state and loads source address 192.168.1.100;
// the header buffer is not cleared.
module ipv4_source_rewrite_checksum_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] data_word
    input  logic        s_tlast,
    input  logic        s_tuser,   // [0] last_is_odd_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_word
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [0] out_odd_byte, [1] header_invalid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import isrc_pkg::*;

    logic [31:0]       src_addr_reg;
    logic              q_push;
    cmd_t              q_cmd;
    logic              q_full;
    logic              q_pop;
    cmd_t              q_head;
    logic              q_empty;
    logic              ram_we;
    logic [HDR_AW-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic              ram_re;
    logic [HDR_AW-1:0] ram_raddr;
    logic [15:0]       ram_rdata;
    logic              replay_done;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_addr_reg <= SRC_ADDR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            src_addr_reg <= cfg_data;
        end
    end

    isrc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .src_addr    (src_addr_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .replay_done (replay_done)
    );

    isrc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (q_head),
        .empty    (q_empty)
    );

    isrc_ram #(
        .WIDTH (16),
        .DEPTH (MAX_HEADER_WORDS)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    isrc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .src_addr    (src_addr_reg),
        .replay_done (replay_done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

// File: hw/rtl/isrc_checker.sv
// Port-level checker for the IPv4 source rewrite checksum unit, with its bind.
`include "ipv4_source_rewrite_checksum_unit_defines.svh"

module isrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    logic mid_pkt_reg;
    logic prev_bad_reg;

    // track whether the output is inside a packet and that packet's flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_pkt_reg  <= 1'b0;
            prev_bad_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            mid_pkt_reg  <= !m_tlast;
            prev_bad_reg <= m_tuser[1];
        end
    end

    `ISRC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    `ISRC_ASSERT(a_odd_only_on_last, m_tvalid |-> (!m_tuser[0] || m_tlast))
    `ISRC_ASSERT(a_invalid_flag_per_packet, m_tvalid && mid_pkt_reg |-> (m_tuser[1] == prev_bad_reg))
    `ISRC_ASSERT_RST(a_reset_clears_output, !aresetn |=> !m_tvalid)

endmodule

bind ipv4_source_rewrite_checksum_unit isrc_checker u_isrc_checker (.*);
